// ----- design/cao_pkg.sv -----
// ----------------------------------------------------------------------------
// cao_pkg
// Shared types, constants and the divide-by-255 helper for the coverage blend.
// ----------------------------------------------------------------------------
package cao_pkg;

	localparam logic [7:0] CHAN_MAX = 8'hFF;

	// register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_TEXT_ALPHA = 2'd0,
		REG_TEXT_RED   = 2'd1,
		REG_TEXT_GREEN = 2'd2,
		REG_TEXT_BLUE  = 2'd3
	} cfg_idx_t;

	// three color lanes: 0 red, 1 green, 2 blue
	typedef logic [2:0][7:0]  rgb_t;
	typedef logic [2:0][16:0] num3_t;

	typedef struct packed {
		logic [7:0] sa;
		logic [7:0] q;   // floor(da * (255 - sa) / 255)
		logic [7:0] r;   // remainder of the above
		logic [7:0] oa;
	} alpha_t;

	// zero-coverage pass-through data
	typedef struct packed {
		logic zero;
		rgb_t dc;
	} byp_t;

	typedef struct packed {
		logic [8:0] q;
		logic [7:0] r;
	} quot_t;

	// floor(x / 255) and x mod 255 for a 16-bit value: reciprocal estimate,
	// which is low by at most one, then a single correction
	function automatic quot_t div255(input logic [15:0] x);
		logic [16:0] t;
		logic [8:0]  qe;
		logic [16:0] re;
		quot_t       res;
		t  = {1'b0, x} + {9'b0, x[15:8]};
		qe = t[16:8];
		re = {1'b0, x} - ({qe, 8'b0} - {8'b0, qe});
		if (re >= 17'd255) begin
			res.q = qe + 9'd1;
			res.r = 8'(re - 17'd255);
		end else begin
			res.q = qe;
			res.r = re[7:0];
		end
		return res;
	endfunction

endpackage

// ----- design/cao_alpha.sv -----
// ----------------------------------------------------------------------------
// cao_alpha
// Stages 1-4: source alpha, destination weight and output alpha.
// ----------------------------------------------------------------------------
module cao_alpha (
	input  logic             clk,
	input  logic [3:0]       en,
	input  logic [7:0]       coverage,
	input  logic [7:0]       dest_alpha,
	input  cao_pkg::rgb_t    dest_rgb,
	input  logic [7:0]       text_alpha,
	output cao_pkg::alpha_t  alpha_s4,
	output cao_pkg::byp_t    byp_s4
);

	logic [15:0]    prod_s1;
	logic [7:0]     da_s1;
	cao_pkg::byp_t  byp_s1;

	logic [7:0]     sa_s2;
	logic [7:0]     da_s2;
	cao_pkg::byp_t  byp_s2;

	logic [15:0]    x_s3;
	logic [7:0]     sa_s3;
	cao_pkg::byp_t  byp_s3;

	cao_pkg::quot_t sa_div;
	cao_pkg::quot_t x_div;

	always_comb begin
		sa_div = cao_pkg::div255(prod_s1);
		x_div  = cao_pkg::div255(x_s3);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s1     <= 16'(coverage) * 16'(text_alpha);
			da_s1       <= dest_alpha;
			byp_s1.zero <= (coverage == 8'd0);
			byp_s1.dc   <= dest_rgb;
		end
		if (en[1]) begin
			sa_s2  <= sa_div.q[7:0];
			da_s2  <= da_s1;
			byp_s2 <= byp_s1;
		end
		if (en[2]) begin
			x_s3   <= 16'(da_s2) * 16'(cao_pkg::CHAN_MAX - sa_s2);
			sa_s3  <= sa_s2;
			byp_s3 <= byp_s2;
		end
		if (en[3]) begin
			alpha_s4.sa <= sa_s3;
			alpha_s4.q  <= x_div.q[7:0];
			alpha_s4.r  <= x_div.r;
			alpha_s4.oa <= sa_s3 + x_div.q[7:0];
			byp_s4      <= byp_s3;
		end
	end

endmodule

// ----- design/cao_mix.sv -----
// ----------------------------------------------------------------------------
// cao_mix
// Stages 5-7: per-lane weighted sum of text and destination color.
// ----------------------------------------------------------------------------
module cao_mix (
	input  logic             clk,
	input  logic [2:0]       en,
	input  cao_pkg::alpha_t  alpha_s4,
	input  cao_pkg::byp_t    byp_s4,
	input  cao_pkg::rgb_t    text_rgb,
	output cao_pkg::num3_t   num_s7,
	output logic [7:0]       oa_s7,
	output cao_pkg::byp_t    byp_s7
);

	logic [2:0][15:0] m1_s5;
	logic [2:0][15:0] m2_s5;
	logic [2:0][15:0] m3_s5;
	logic [7:0]       oa_s5;
	cao_pkg::byp_t    byp_s5;

	logic [2:0][16:0] s12_s6;
	logic [2:0][7:0]  d3_s6;
	logic [7:0]       oa_s6;
	cao_pkg::byp_t    byp_s6;

	cao_pkg::quot_t   m3_div [3];

	// dc*da*(255-sa)/255 = dc*q + floor(dc*r/255), with q, r from stage 4
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m3_div[i] = cao_pkg::div255(m3_s5[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				m1_s5[i] <= 16'(text_rgb[i]) * 16'(alpha_s4.sa);
				m2_s5[i] <= 16'(byp_s4.dc[i]) * 16'(alpha_s4.q);
				m3_s5[i] <= 16'(byp_s4.dc[i]) * 16'(alpha_s4.r);
			end
			oa_s5  <= alpha_s4.oa;
			byp_s5 <= byp_s4;
		end
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				s12_s6[i] <= 17'(m1_s5[i]) + 17'(m2_s5[i]);
				d3_s6[i]  <= m3_div[i].q[7:0];
			end
			oa_s6  <= oa_s5;
			byp_s6 <= byp_s5;
		end
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				num_s7[i] <= s12_s6[i] + 17'(d3_s6[i]);
			end
			oa_s7  <= oa_s6;
			byp_s7 <= byp_s6;
		end
	end

endmodule

// ----- design/cao_div.sv -----
// ----------------------------------------------------------------------------
// cao_div
// Stages 8-10: restoring division of each lane sum by output alpha, three
// quotient bits per stage, then the zero-coverage and zero-alpha selects.
// ----------------------------------------------------------------------------
module cao_div (
	input  logic            clk,
	input  logic [2:0]      en,
	input  cao_pkg::num3_t  num_s7,
	input  logic [7:0]      oa_s7,
	input  cao_pkg::byp_t   byp_s7,
	output logic [7:0]      alpha_s10,
	output cao_pkg::rgb_t   rgb_s10
);

	typedef struct packed {
		logic [16:0] rem;
		logic [8:0]  quo;
	} step_t;

	// sum < 512 * oa, so nine quotient bits cover it
	function automatic step_t div_step3(input step_t st, input logic [7:0] oa,
			input int top_bit);
		step_t       s;
		logic [16:0] d;
		s = st;
		for (int k = 0; k < 3; k++) begin
			d = 17'(oa) << (top_bit - k);
			if (s.rem >= d) begin
				s.rem = s.rem - d;
				s.quo = {s.quo[7:0], 1'b1};
			end else begin
				s.quo = {s.quo[7:0], 1'b0};
			end
		end
		return s;
	endfunction

	step_t         st_s8 [3];
	logic [7:0]    oa_s8;
	cao_pkg::byp_t byp_s8;

	step_t         st_s9 [3];
	logic [7:0]    oa_s9;
	cao_pkg::byp_t byp_s9;

	step_t         nx8 [3];
	step_t         nx9 [3];
	step_t         nx10 [3];
	cao_pkg::rgb_t rgb_nx;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nx8[i]  = div_step3({num_s7[i], 9'd0}, oa_s7, 8);
			nx9[i]  = div_step3(st_s8[i], oa_s8, 5);
			nx10[i] = div_step3(st_s9[i], oa_s9, 2);
			if (byp_s9.zero) begin
				rgb_nx[i] = byp_s9.dc[i];
			end else if (oa_s9 == 8'd0) begin
				rgb_nx[i] = 8'd0;
			end else begin
				rgb_nx[i] = nx10[i].quo[7:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				st_s8[i] <= nx8[i];
			end
			oa_s8  <= oa_s7;
			byp_s8 <= byp_s7;
		end
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				st_s9[i] <= nx9[i];
			end
			oa_s9  <= oa_s8;
			byp_s9 <= byp_s8;
		end
		if (en[2]) begin
			alpha_s10 <= oa_s9;
			rgb_s10   <= rgb_nx;
		end
	end

endmodule

// ----- design/coverage_alpha_over_blend.sv -----
// ----------------------------------------------------------------------------
// coverage_alpha_over_blend
// Source-over blend of a glyph coverage sample in the text color onto an
// ARGB8888 destination pixel.
// ----------------------------------------------------------------------------
// Takes one item per clock unless out_ready stalls the full pipeline. It is
// a ten-stage pipeline: four stages for the alpha terms, three for the
// per-channel weighted sums, and three for the division by output alpha,
// which retires three quotient bits per stage. Stalls from out_ready are
// absorbed by any empty stage, so in_ready stays high while the pipeline has
// a bubble. Text color registers are written through the cfg port at any
// time; cfg_ready is always high and writes should land while no item is in
// flight.
module coverage_alpha_over_blend (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] coverage,
	input  logic [7:0] dest_alpha,
	input  logic [7:0] dest_red,
	input  logic [7:0] dest_green,
	input  logic [7:0] dest_blue,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] blended_alpha,
	output logic [7:0] blended_red,
	output logic [7:0] blended_green,
	output logic [7:0] blended_blue,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int NSTAGE = 10;

	logic [7:0] text_alpha_q;
	logic [7:0] text_red_q;
	logic [7:0] text_green_q;
	logic [7:0] text_blue_q;

	logic [NSTAGE-1:0] vld_q;
	logic [NSTAGE-1:0] ld;

	cao_pkg::rgb_t   dest_rgb;
	cao_pkg::rgb_t   text_rgb;
	cao_pkg::alpha_t alpha_s4;
	cao_pkg::byp_t   byp_s4;
	cao_pkg::num3_t  num_s7;
	logic [7:0]      oa_s7;
	cao_pkg::byp_t   byp_s7;
	cao_pkg::rgb_t   rgb_s10;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_alpha_q <= cao_pkg::CHAN_MAX;
			text_red_q   <= cao_pkg::CHAN_MAX;
			text_green_q <= cao_pkg::CHAN_MAX;
			text_blue_q  <= cao_pkg::CHAN_MAX;
		end else if (cfg_valid) begin
			case (cao_pkg::cfg_idx_t'(cfg_index))
				cao_pkg::REG_TEXT_ALPHA: text_alpha_q <= cfg_data;
				cao_pkg::REG_TEXT_RED:   text_red_q   <= cfg_data;
				cao_pkg::REG_TEXT_GREEN: text_green_q <= cfg_data;
				cao_pkg::REG_TEXT_BLUE:  text_blue_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or its item moves on
	always_comb begin
		ld[NSTAGE-1] = !vld_q[NSTAGE-1] || out_ready;
		for (int k = NSTAGE - 2; k >= 0; k--) begin
			ld[k] = !vld_q[k] || ld[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NSTAGE; k++) begin
				if (ld[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = ld[0];
	assign out_valid = vld_q[NSTAGE-1];

	assign dest_rgb = {dest_blue, dest_green, dest_red};
	assign text_rgb = {text_blue_q, text_green_q, text_red_q};

	cao_alpha u_alpha (
		.clk        (clk),
		.en         (ld[3:0]),
		.coverage   (coverage),
		.dest_alpha (dest_alpha),
		.dest_rgb   (dest_rgb),
		.text_alpha (text_alpha_q),
		.alpha_s4   (alpha_s4),
		.byp_s4     (byp_s4)
	);

	cao_mix u_mix (
		.clk      (clk),
		.en       (ld[6:4]),
		.alpha_s4 (alpha_s4),
		.byp_s4   (byp_s4),
		.text_rgb (text_rgb),
		.num_s7   (num_s7),
		.oa_s7    (oa_s7),
		.byp_s7   (byp_s7)
	);

	cao_div u_div (
		.clk       (clk),
		.en        (ld[9:7]),
		.num_s7    (num_s7),
		.oa_s7     (oa_s7),
		.byp_s7    (byp_s7),
		.alpha_s10 (blended_alpha),
		.rgb_s10   (rgb_s10)
	);

	assign blended_red   = rgb_s10[0];
	assign blended_green = rgb_s10[1];
	assign blended_blue  = rgb_s10[2];

endmodule
